@@ design/uecal_pkg.sv @@
// ----------------------------------------------------------------------------
// Epoch to calendar package
// Widths, constants, datapath opcodes and the month length table shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package uecal_pkg;

   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;

   localparam int unsigned DAYS_W = 16;
   localparam int unsigned SOD_W  = 17;
   localparam int unsigned MOD_W  = 11;
   localparam int unsigned YLEN_W = 9;

   localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [MOD_W-1:0]   MINS_PER_HOUR = 11'd60;

   // Whole days: (seconds >> 7) / 675, by a rounded-up reciprocal of 675.
   localparam int unsigned DAY_PRE    = 7;
   localparam int unsigned DAY_SHIFT  = 35;
   localparam int unsigned DAY_PROD_W = 51;
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;

   // Minute of the day: (seconds of the day >> 2) / 15.
   localparam int unsigned MOD_SHIFT  = 19;
   localparam int unsigned MOD_PROD_W = 31;
   localparam logic [15:0] MOD_RECIP  = 16'd34953;

   // Hour of the day: (minute of the day >> 2) / 15.
   localparam int unsigned HOUR_SHIFT  = 13;
   localparam int unsigned HOUR_PROD_W = 19;
   localparam logic [9:0]  HOUR_RECIP  = 10'd547;

   localparam logic [YEAR_W-1:0]  BASE_YEAR    = 12'd1970;
   localparam logic [1:0]         BASE_MOD4    = 2'd2;
   localparam logic [6:0]         BASE_MOD100  = 7'd70;
   localparam logic [8:0]         BASE_MOD400  = 9'd370;
   localparam logic [6:0]         LAST_MOD100  = 7'd99;
   localparam logic [8:0]         LAST_MOD400  = 9'd399;
   localparam logic [YLEN_W-1:0]  DAYS_LEAP    = 9'd366;
   localparam logic [YLEN_W-1:0]  DAYS_COMMON  = 9'd365;
   localparam logic [MONTH_W-1:0] JANUARY      = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;
   localparam logic [DAYS_W-1:0]  LAST_DAY_IDX = 16'd30;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DAY_DIV,
      OP_DAY_REM,
      OP_MOD_DIV,
      OP_HOUR_DIV,
      OP_MIN_REM,
      OP_YEAR_STEP,
      OP_MONTH_STEP,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } status_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ design/uecal_ctrl.sv @@
// ----------------------------------------------------------------------------
// Epoch to calendar controller
// Sequences the fixed division steps, the year and month reductions and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module uecal_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  uecal_pkg::status_type status,
   output uecal_pkg::op_type     op
);
   import uecal_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAY_DIV,
      ST_DAY_REM,
      ST_MOD_DIV,
      ST_HOUR_DIV,
      ST_MIN_REM,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:     op = req_valid ? OP_LOAD : OP_NONE;
         ST_DAY_DIV:  op = OP_DAY_DIV;
         ST_DAY_REM:  op = OP_DAY_REM;
         ST_MOD_DIV:  op = OP_MOD_DIV;
         ST_HOUR_DIV: op = OP_HOUR_DIV;
         ST_MIN_REM:  op = OP_MIN_REM;
         ST_YEAR:     op = status.year_done ? OP_NONE : OP_YEAR_STEP;
         ST_MONTH:    op = status.month_done ? OP_NONE : OP_MONTH_STEP;
         ST_FINISH:   op = out_free ? OP_PUBLISH : OP_NONE;
         default:     op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result moves to the output register once it is free.
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DAY_DIV;
               end
            end
            ST_DAY_DIV: begin
               state_ff <= ST_DAY_REM;
            end
            ST_DAY_REM: begin
               state_ff <= ST_MOD_DIV;
            end
            ST_MOD_DIV: begin
               state_ff <= ST_HOUR_DIV;
            end
            ST_HOUR_DIV: begin
               state_ff <= ST_MIN_REM;
            end
            ST_MIN_REM: begin
               state_ff <= ST_YEAR;
            end
            ST_YEAR: begin
               if (status.year_done) begin
                  state_ff <= ST_MONTH;
               end
            end
            ST_MONTH: begin
               if (status.month_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/uecal_dp.sv @@
// ----------------------------------------------------------------------------
// Epoch to calendar datapath
// Reciprocal-multiply dividers for days, minutes and hours, year and month
// subtractors with leap tracking, and the output register.
// ----------------------------------------------------------------------------
module uecal_dp (
   input  logic                               clock,
   input  uecal_pkg::op_type                  op,
   output uecal_pkg::status_type              status,
   input  logic [uecal_pkg::EPOCH_W-1:0]      req_epoch_seconds,
   output logic [uecal_pkg::YEAR_W-1:0]       rsp_cal_year,
   output logic [uecal_pkg::MONTH_W-1:0]      rsp_cal_month,
   output logic [uecal_pkg::DAY_W-1:0]        rsp_cal_day,
   output logic [uecal_pkg::HOUR_W-1:0]       rsp_cal_hour,
   output logic [uecal_pkg::MINUTE_W-1:0]     rsp_cal_minute
);
   import uecal_pkg::*;

   logic [EPOCH_W-1:0]  secs_ff;
   logic [DAYS_W-1:0]   days_ff;
   logic [SOD_W-1:0]    sod_ff;
   logic [MOD_W-1:0]    mod_ff;
   logic [HOUR_W-1:0]   hour_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [1:0]          mod4_ff;
   logic [6:0]          mod100_ff;
   logic [8:0]          mod400_ff;

   logic [YEAR_W-1:0]   out_year_ff;
   logic [MONTH_W-1:0]  out_month_ff;
   logic [DAY_W-1:0]    out_day_ff;
   logic [HOUR_W-1:0]   out_hour_ff;
   logic [MINUTE_W-1:0] out_minute_ff;

   logic [DAY_PROD_W-1:0]  day_prod;
   logic [EPOCH_W-1:0]     day_secs;
   logic [EPOCH_W-1:0]     sod_full;
   logic [MOD_PROD_W-1:0]  mod_prod;
   logic [HOUR_PROD_W-1:0] hour_prod;
   logic [MOD_W-1:0]       min_full;
   logic                   leap;
   logic [YLEN_W-1:0]      ylen;
   logic [DAY_W-1:0]       mlen;
   logic [DAY_W-1:0]       day_idx;

   // The reciprocals are rounded up; the rounding error stays small enough
   // that the quotient is exact over the whole input range of each step.
   assign day_prod  = DAY_PROD_W'(secs_ff[EPOCH_W-1:DAY_PRE]) * DAY_PROD_W'(DAY_RECIP);
   assign day_secs  = EPOCH_W'(days_ff) * SECS_PER_DAY;
   assign sod_full  = secs_ff - day_secs;
   assign mod_prod  = MOD_PROD_W'(sod_ff[SOD_W-1:2]) * MOD_PROD_W'(MOD_RECIP);
   assign hour_prod = HOUR_PROD_W'(mod_ff[MOD_W-1:2]) * HOUR_PROD_W'(HOUR_RECIP);
   assign min_full  = mod_ff - MOD_W'(hour_ff) * MINS_PER_HOUR;

   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
   assign mlen = month_length(month_ff, leap);

   assign status.year_done  = (days_ff < DAYS_W'(ylen));
   assign status.month_done = (month_ff == DECEMBER) || (days_ff < DAYS_W'(mlen));

   assign day_idx = (days_ff > LAST_DAY_IDX) ? LAST_DAY_IDX[DAY_W-1:0] : days_ff[DAY_W-1:0];

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            secs_ff   <= req_epoch_seconds;
            year_ff   <= BASE_YEAR;
            month_ff  <= JANUARY;
            mod4_ff   <= BASE_MOD4;
            mod100_ff <= BASE_MOD100;
            mod400_ff <= BASE_MOD400;
         end
         OP_DAY_DIV: begin
            days_ff <= day_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
         end
         OP_DAY_REM: begin
            sod_ff <= sod_full[SOD_W-1:0];
         end
         OP_MOD_DIV: begin
            mod_ff <= mod_prod[MOD_SHIFT+MOD_W-1:MOD_SHIFT];
         end
         OP_HOUR_DIV: begin
            hour_ff <= hour_prod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
         end
         OP_MIN_REM: begin
            minute_ff <= min_full[MINUTE_W-1:0];
         end
         OP_YEAR_STEP: begin
            days_ff   <= days_ff - DAYS_W'(ylen);
            year_ff   <= year_ff + 12'd1;
            mod4_ff   <= mod4_ff + 2'd1;
            mod100_ff <= (mod100_ff == LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
            mod400_ff <= (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
         end
         OP_MONTH_STEP: begin
            days_ff  <= days_ff - DAYS_W'(mlen);
            month_ff <= month_ff + 4'd1;
         end
         OP_PUBLISH: begin
            out_year_ff   <= year_ff;
            out_month_ff  <= month_ff;
            out_day_ff    <= day_idx + 5'd1;
            out_hour_ff   <= hour_ff;
            out_minute_ff <= minute_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_cal_year   = out_year_ff;
   assign rsp_cal_month  = out_month_ff;
   assign rsp_cal_day    = out_day_ff;
   assign rsp_cal_hour   = out_hour_ff;
   assign rsp_cal_minute = out_minute_ff;

endmodule

@@ design/unix_epoch_to_calendar_top.sv @@
// An accepted item runs through the division steps, then Y year steps and M month steps,
// where Y (0..136) is the number of whole years and M (0..11) the number of whole months
// subtracted, before rsp_valid rises. No new item is taken in until the last one is published.
// A finished item waits in the output register while the next one is taken in.
// Synchronous active-high reset returns the controller to idle and clears rsp_valid.
// ----------------------------------------------------------------------------
// Unix epoch to calendar converter
// Converts an unsigned 32-bit seconds count to UTC year, month, day, hour and
// minute using a controller and a shared iterative datapath.
// ----------------------------------------------------------------------------
module unix_epoch_to_calendar_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [uecal_pkg::EPOCH_W-1:0]  req_epoch_seconds,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [uecal_pkg::YEAR_W-1:0]   rsp_cal_year,
   output logic [uecal_pkg::MONTH_W-1:0]  rsp_cal_month,
   output logic [uecal_pkg::DAY_W-1:0]    rsp_cal_day,
   output logic [uecal_pkg::HOUR_W-1:0]   rsp_cal_hour,
   output logic [uecal_pkg::MINUTE_W-1:0] rsp_cal_minute
);
   import uecal_pkg::*;

   op_type     op;
   status_type status;

   uecal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   uecal_dp u_dp (
      .clock             (clock),
      .op                (op),
      .status            (status),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_cal_year      (rsp_cal_year),
      .rsp_cal_month     (rsp_cal_month),
      .rsp_cal_day       (rsp_cal_day),
      .rsp_cal_hour      (rsp_cal_hour),
      .rsp_cal_minute    (rsp_cal_minute)
   );

   // The controller is busy in the cycle after it takes an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still ready after an item was accepted");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_year >= BASE_YEAR) && (rsp_cal_year <= 12'd2106))
      else $error("year out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_month >= JANUARY) && (rsp_cal_month <= DECEMBER))
      else $error("month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_hour <= 5'd23) && (rsp_cal_minute <= 6'd59)
                    && (rsp_cal_day != 5'd0))
      else $error("time of day or day of month out of range");

endmodule
